// ----- design/i8080_alu_with_flags_defines.svh -----
// ----------------------------------------------------------------------------
// i8080 alu assertion macros
// shared property templates for the concurrent checks of the alu pipeline
// ----------------------------------------------------------------------------
`ifndef I8080_ALU_WITH_FLAGS_DEFINES_SVH
`define I8080_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define I8080_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define I8080_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/i8080alu_pkg.sv -----
// ----------------------------------------------------------------------------
// i8080 alu package
// operation codes, flag bit positions, adjust constants and stage payloads
// ----------------------------------------------------------------------------
package i8080alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_ADC = 5'd1,
        OP_SUB = 5'd2,
        OP_SBB = 5'd3,
        OP_ANA = 5'd4,
        OP_XRA = 5'd5,
        OP_ORA = 5'd6,
        OP_CMP = 5'd7,
        OP_INR = 5'd8,
        OP_DCR = 5'd9,
        OP_RLC = 5'd10,
        OP_RRC = 5'd11,
        OP_RAL = 5'd12,
        OP_RAR = 5'd13,
        OP_DAA = 5'd14,
        OP_CMA = 5'd15,
        OP_STC = 5'd16,
        OP_CMC = 5'd17,
        OP_DAD = 5'd18
    } t_alu_op;

    // flag byte layout
    localparam int FL_S  = 7;
    localparam int FL_Z  = 6;
    localparam int FL_AC = 4;
    localparam int FL_P  = 2;
    localparam int FL_CY = 0;

    // decimal adjust
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [3:0] BCD_MAX    = 4'h9;

    typedef struct packed {
        logic [4:0]  func;
        logic [7:0]  acc_in;
        logic [7:0]  operand;
        logic [7:0]  flags_in;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_alu_item;

    // execute -> adjust
    typedef struct packed {
        logic [7:0]  res;
        logic [7:0]  zval;
        logic [7:0]  flags;
        logic        zsp_en;
        logic        daa_hi;
        logic [15:0] wsum;
    } t_exec_out;

    // adjust -> flag stage
    typedef struct packed {
        logic [7:0]  res;
        logic [7:0]  zval;
        logic [7:0]  flags;
        logic        zsp_en;
        logic [15:0] wsum;
    } t_adj_out;

    typedef struct packed {
        logic [15:0] word_sum;
        logic [7:0]  flags_out;
        logic [7:0]  result;
    } t_alu_result;

endpackage

// ----- design/i8080_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// i8080 alu with flags
// 8080 arithmetic-logic unit with flag update, three-stage stream pipeline
// ----------------------------------------------------------------------------
// Takes one operation per clock while no stage is stalled and returns one
// result per operation, in order, through the execute, decimal adjust and
// flag/output register stages. Every stage carries its own valid bit and loads
// whenever it is empty or the stage after it moves, so bubbles close up and
// a new transaction is taken while a finished result still waits in the
// output register, as long as some stage ahead of it is free. The longest
// path is the execute stage: the 9-bit add/subtract and the 16-bit double
// add in parallel followed by the result select. Flag bits an operation
// does not touch, including the unused bits 5, 3 and 1, pass through.
`include "i8080_alu_with_flags_defines.svh"

module i8080_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[4:0], acc_in[12:5], operand[20:13], flags_in[28:21],
    // word_a[44:29], word_b[60:45], zero pad[63:61]
    input  logic [63:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result[7:0], flags_out[15:8], word_sum[31:16]
    output logic [31:0] m_axis_tdata
);

    i8080alu_pkg::t_alu_item   s_item;
    i8080alu_pkg::t_exec_out   exec_data;
    i8080alu_pkg::t_adj_out    adj_data;
    i8080alu_pkg::t_alu_result out_data;

    logic exec_valid;
    logic adj_ready;
    logic adj_valid;
    logic flg_ready;

    // unpack the input transaction
    assign s_item.func     = s_axis_tdata[4:0];
    assign s_item.acc_in   = s_axis_tdata[12:5];
    assign s_item.operand  = s_axis_tdata[20:13];
    assign s_item.flags_in = s_axis_tdata[28:21];
    assign s_item.word_a   = s_axis_tdata[44:29];
    assign s_item.word_b   = s_axis_tdata[60:45];

    // stage 1: decode, adder, logic, rotates, low decimal fix, double add
    i8080alu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .o_valid (exec_valid),
        .i_ready (adj_ready),
        .o_data  (exec_data)
    );

    // stage 2: high decimal fix
    i8080alu_adjust u_adjust (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (exec_valid),
        .o_ready (adj_ready),
        .i_data  (exec_data),
        .o_valid (adj_valid),
        .i_ready (flg_ready),
        .o_data  (adj_data)
    );

    // stage 3: sign/zero/parity, output register
    i8080alu_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (adj_valid),
        .o_ready (flg_ready),
        .i_data  (adj_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_data)
    );

    // pack the output transaction
    assign m_axis_tdata = {out_data.word_sum, out_data.flags_out, out_data.result};

    // an empty output register means the whole pipeline can take a transaction
    `I8080_ASSERT_IMP(a_ready_when_out_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")

    // a transfer from execute into adjust must show up as valid in the next cycle
    `I8080_ASSERT_NXT(a_exec_to_adjust, i_clk, i_rst_n, exec_valid && adj_ready, adj_valid, "item lost between execute and adjust")

    // the high decimal fix only ever comes with a sign/zero/parity update
    `I8080_ASSERT_IMP(a_daa_hi_sets_zsp, i_clk, i_rst_n, exec_valid && exec_data.daa_hi, exec_data.zsp_en, "decimal fix without flag update")

endmodule

// ----- design/i8080alu_exec.sv -----
// ----------------------------------------------------------------------------
// i8080 alu execute stage
// decodes the operation, runs the 8-bit adder, logic, rotates, the low
// decimal adjust and the 16-bit double add, then registers the outcome
// ----------------------------------------------------------------------------
module i8080alu_exec (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  i8080alu_pkg::t_alu_item i_item,
    output logic                    o_valid,
    input  logic                    i_ready,
    output i8080alu_pkg::t_exec_out o_data
);

    i8080alu_pkg::t_alu_op   op;
    i8080alu_pkg::t_exec_out n_data;
    i8080alu_pkg::t_exec_out r_data;
    logic                    r_valid;

    logic [7:0]  a;
    logic [7:0]  d;
    logic [7:0]  f;
    logic        cy;
    logic        is_sub;
    logic [7:0]  add_b;
    logic        add_cin;
    logic [8:0]  add_sum;
    logic        add_hc;
    logic        add_cy;
    logic [7:0]  inc_dec;
    logic        lo_big;
    logic        daa_lo_fix;
    logic        daa_hi_fix;
    logic [7:0]  daa_lo_sum;
    logic [16:0] wsum17;

    assign op = i8080alu_pkg::t_alu_op'(i_item.func);
    assign a  = i_item.acc_in;
    assign d  = i_item.operand;
    assign f  = i_item.flags_in;
    assign cy = f[i8080alu_pkg::FL_CY];

    // one shared adder for add, subtract and compare
    assign is_sub = (op == i8080alu_pkg::OP_SUB) || (op == i8080alu_pkg::OP_SBB) ||
                    (op == i8080alu_pkg::OP_CMP);
    assign add_b  = is_sub ? ~d : d;

    always_comb begin
        case (op)
            i8080alu_pkg::OP_ADC: add_cin = cy;
            i8080alu_pkg::OP_SBB: add_cin = ~cy;
            i8080alu_pkg::OP_SUB,
            i8080alu_pkg::OP_CMP: add_cin = 1'b1;
            default:              add_cin = 1'b0;
        endcase
    end

    assign add_sum = {1'b0, a} + {1'b0, add_b} + {8'd0, add_cin};
    assign add_hc  = add_sum[4] ^ a[4] ^ add_b[4];
    // borrow is the inverted carry on subtract
    assign add_cy  = add_sum[8] ^ is_sub;

    assign inc_dec = (op == i8080alu_pkg::OP_DCR) ? (d - 8'd1) : (d + 8'd1);

    // low nibble of decimal adjust; high nibble finishes in the next stage
    assign lo_big     = a[3:0] > i8080alu_pkg::BCD_MAX;
    assign daa_lo_fix = lo_big || f[i8080alu_pkg::FL_AC];
    assign daa_hi_fix = (a[7:4] > i8080alu_pkg::BCD_MAX) || cy ||
                        ((a[7:4] >= i8080alu_pkg::BCD_MAX) && lo_big);
    assign daa_lo_sum = a + i8080alu_pkg::DAA_LO_ADJ;

    assign wsum17 = {1'b0, i_item.word_a} + {1'b0, i_item.word_b};

    always_comb begin
        n_data        = '0;
        n_data.res    = a;
        n_data.zval   = a;
        n_data.flags  = f;
        n_data.zsp_en = 1'b0;
        n_data.daa_hi = 1'b0;
        n_data.wsum   = '0;
        unique case (op) inside
            i8080alu_pkg::OP_ADD, i8080alu_pkg::OP_ADC,
            i8080alu_pkg::OP_SUB, i8080alu_pkg::OP_SBB: begin
                n_data.res                       = add_sum[7:0];
                n_data.zval                      = add_sum[7:0];
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = add_hc;
                n_data.flags[i8080alu_pkg::FL_CY] = add_cy;
            end
            i8080alu_pkg::OP_CMP: begin
                n_data.zval                      = add_sum[7:0];
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = add_hc;
                n_data.flags[i8080alu_pkg::FL_CY] = add_cy;
            end
            i8080alu_pkg::OP_ANA: begin
                n_data.res                       = a & d;
                n_data.zval                      = a & d;
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = a[3] | d[3];
                n_data.flags[i8080alu_pkg::FL_CY] = 1'b0;
            end
            i8080alu_pkg::OP_XRA: begin
                n_data.res                       = a ^ d;
                n_data.zval                      = a ^ d;
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = 1'b0;
                n_data.flags[i8080alu_pkg::FL_CY] = 1'b0;
            end
            i8080alu_pkg::OP_ORA: begin
                n_data.res                       = a | d;
                n_data.zval                      = a | d;
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = 1'b0;
                n_data.flags[i8080alu_pkg::FL_CY] = 1'b0;
            end
            i8080alu_pkg::OP_INR: begin
                n_data.res                       = inc_dec;
                n_data.zval                      = inc_dec;
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = (inc_dec[3:0] == 4'h0);
            end
            i8080alu_pkg::OP_DCR: begin
                n_data.res                       = inc_dec;
                n_data.zval                      = inc_dec;
                n_data.zsp_en                    = 1'b1;
                n_data.flags[i8080alu_pkg::FL_AC] = (inc_dec[3:0] != 4'hf);
            end
            i8080alu_pkg::OP_RLC: begin
                n_data.res                       = {a[6:0], a[7]};
                n_data.flags[i8080alu_pkg::FL_CY] = a[7];
            end
            i8080alu_pkg::OP_RRC: begin
                n_data.res                       = {a[0], a[7:1]};
                n_data.flags[i8080alu_pkg::FL_CY] = a[0];
            end
            i8080alu_pkg::OP_RAL: begin
                n_data.res                       = {a[6:0], cy};
                n_data.flags[i8080alu_pkg::FL_CY] = a[7];
            end
            i8080alu_pkg::OP_RAR: begin
                n_data.res                       = {cy, a[7:1]};
                n_data.flags[i8080alu_pkg::FL_CY] = a[0];
            end
            i8080alu_pkg::OP_DAA: begin
                n_data.res    = daa_lo_fix ? daa_lo_sum : a;
                n_data.zval   = daa_lo_fix ? daa_lo_sum : a;
                n_data.zsp_en = 1'b1;
                n_data.daa_hi = daa_hi_fix;
                // carry out of the low nibble only when it gets corrected
                n_data.flags[i8080alu_pkg::FL_AC] = daa_lo_fix ? lo_big :
                                                    f[i8080alu_pkg::FL_AC];
                n_data.flags[i8080alu_pkg::FL_CY] = cy | daa_hi_fix;
            end
            i8080alu_pkg::OP_CMA: begin
                n_data.res = ~a;
            end
            i8080alu_pkg::OP_STC: begin
                n_data.flags[i8080alu_pkg::FL_CY] = 1'b1;
            end
            i8080alu_pkg::OP_CMC: begin
                n_data.flags[i8080alu_pkg::FL_CY] = ~cy;
            end
            i8080alu_pkg::OP_DAD: begin
                n_data.wsum                      = wsum17[15:0];
                n_data.flags[i8080alu_pkg::FL_CY] = wsum17[16];
            end
            default: begin
                n_data.res = a;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/i8080alu_adjust.sv -----
// ----------------------------------------------------------------------------
// i8080 alu adjust stage
// applies the high-nibble decimal correction and registers the result
// ----------------------------------------------------------------------------
module i8080alu_adjust (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  i8080alu_pkg::t_exec_out i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output i8080alu_pkg::t_adj_out  o_data
);

    i8080alu_pkg::t_adj_out n_data;
    i8080alu_pkg::t_adj_out r_data;
    logic                   r_valid;
    logic [7:0]             hi_sum;

    assign hi_sum = i_data.res + i8080alu_pkg::DAA_HI_ADJ;

    always_comb begin
        n_data        = '0;
        n_data.res    = i_data.daa_hi ? hi_sum : i_data.res;
        n_data.zval   = i_data.daa_hi ? hi_sum : i_data.zval;
        n_data.flags  = i_data.flags;
        n_data.zsp_en = i_data.zsp_en;
        n_data.wsum   = i_data.wsum;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- design/i8080alu_flags.sv -----
// ----------------------------------------------------------------------------
// i8080 alu flag stage
// forms sign, zero and parity and holds the finished result for output
// ----------------------------------------------------------------------------
module i8080alu_flags (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  i8080alu_pkg::t_adj_out    i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output i8080alu_pkg::t_alu_result o_data
);

    i8080alu_pkg::t_alu_result n_data;
    i8080alu_pkg::t_alu_result r_data;
    logic                      r_valid;

    always_comb begin
        n_data           = '0;
        n_data.result    = i_data.res;
        n_data.word_sum  = i_data.wsum;
        n_data.flags_out = i_data.flags;
        if (i_data.zsp_en) begin
            n_data.flags_out[i8080alu_pkg::FL_S] = i_data.zval[7];
            n_data.flags_out[i8080alu_pkg::FL_Z] = (i_data.zval == 8'd0);
            // set on even parity
            n_data.flags_out[i8080alu_pkg::FL_P] = ~^i_data.zval;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- verif/tb_i8080_alu_with_flags.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i8080 alu with flags testbench
// directed corner rows followed by random bursts, every result transaction
// checked in order against a typed value or an independent predictor of the alu and flags
// ----------------------------------------------------------------------------
module tb_i8080_alu_with_flags;

    // run sizing
    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 16;     // pipeline is three deep, leave margin
    localparam int CYCLE_LIMIT   = 200000;

    // operation codes the block leaves unused, they pass acc and flags through
    localparam logic [4:0] FUNC_SPARE_LO = 5'd19;
    localparam logic [4:0] FUNC_SPARE_HI = 5'd31;

    // one row of stimulus, with an optional hand-typed expected result
    typedef struct {
        logic [4:0]                func;
        logic [7:0]                acc;
        logic [7:0]                opnd;
        logic [7:0]                flg;
        logic [15:0]               wa;
        logic [15:0]               wb;
        bit                        typed;
        i8080alu_pkg::t_alu_result want;
    } t_alu_vec;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // func[4:0], acc_in[12:5], operand[20:13], flags_in[28:21],
    // word_a[44:29], word_b[60:45], zero pad[63:61]
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // result[7:0], flags_out[15:8], word_sum[31:16]
    logic [31:0] m_axis_tdata;

    // results still owed by the block, oldest first
    i8080alu_pkg::t_alu_result pending_results[$];
    t_alu_vec                  stim_rows[$];
    int                        n_fail    = 0;
    int unsigned               cycle_cnt = 0;

    i8080_alu_with_flags dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // sign, zero and even parity from an 8-bit value
    function automatic logic [7:0] with_zsp(input logic [7:0] f, input logic [7:0] v);
        f[i8080alu_pkg::FL_Z] = (v == 8'h00);
        f[i8080alu_pkg::FL_S] = v[7];
        f[i8080alu_pkg::FL_P] = ~^v;
        return f;
    endfunction

    function automatic i8080alu_pkg::t_alu_result alu_predict(input logic [4:0] func,
                                                input logic [7:0] a, input logic [7:0] d,
                                                input logic [7:0] f_in,
                                                input logic [15:0] wa, input logic [15:0] wb);
        i8080alu_pkg::t_alu_result o;
        logic [7:0]  f, r, nd;
        logic [8:0]  s9, cr;
        logic [16:0] s17;
        logic [3:0]  lo, hi;
        logic        cy;
        f = f_in;
        r = a;
        cy = f_in[i8080alu_pkg::FL_CY];
        o.word_sum = 16'h0000;
        case (func) inside
            i8080alu_pkg::OP_ADD, i8080alu_pkg::OP_ADC: begin
                s9 = {1'b0, a} + {1'b0, d} +
                     {8'h00, (func == i8080alu_pkg::OP_ADC) ? cy : 1'b0};
                cr = s9 ^ {1'b0, d} ^ {1'b0, a};
                r = s9[7:0];
                f = with_zsp(f, r);
                f[i8080alu_pkg::FL_AC] = cr[4];
                f[i8080alu_pkg::FL_CY] = cr[8];
            end
            i8080alu_pkg::OP_SUB, i8080alu_pkg::OP_SBB, i8080alu_pkg::OP_CMP: begin
                // subtract as add of the complement, carry out inverted is the borrow
                nd = ~d;
                s9 = {1'b0, a} + {1'b0, nd} +
                     {8'h00, (func == i8080alu_pkg::OP_SBB) ? ~cy : 1'b1};
                cr = s9 ^ {1'b0, nd} ^ {1'b0, a};
                if (func != i8080alu_pkg::OP_CMP) begin
                    r = s9[7:0];
                end
                f = with_zsp(f, s9[7:0]);
                f[i8080alu_pkg::FL_AC] = cr[4];
                f[i8080alu_pkg::FL_CY] = ~cr[8];
            end
            i8080alu_pkg::OP_ANA: begin
                r = a & d;
                f = with_zsp(f, r);
                f[i8080alu_pkg::FL_AC] = a[3] | d[3];
                f[i8080alu_pkg::FL_CY] = 1'b0;
            end
            i8080alu_pkg::OP_XRA, i8080alu_pkg::OP_ORA: begin
                r = (func == i8080alu_pkg::OP_XRA) ? (a ^ d) : (a | d);
                f = with_zsp(f, r);
                f[i8080alu_pkg::FL_AC] = 1'b0;
                f[i8080alu_pkg::FL_CY] = 1'b0;
            end
            i8080alu_pkg::OP_INR: begin
                r = d + 8'h01;
                f = with_zsp(f, r);
                f[i8080alu_pkg::FL_AC] = (r[3:0] == 4'h0);
            end
            i8080alu_pkg::OP_DCR: begin
                r = d - 8'h01;
                f = with_zsp(f, r);
                f[i8080alu_pkg::FL_AC] = (r[3:0] != 4'hF);
            end
            i8080alu_pkg::OP_RLC: begin
                r = {a[6:0], a[7]};
                f[i8080alu_pkg::FL_CY] = a[7];
            end
            i8080alu_pkg::OP_RRC: begin
                r = {a[0], a[7:1]};
                f[i8080alu_pkg::FL_CY] = a[0];
            end
            i8080alu_pkg::OP_RAL: begin
                r = {a[6:0], cy};
                f[i8080alu_pkg::FL_CY] = a[7];
            end
            i8080alu_pkg::OP_RAR: begin
                r = {cy, a[7:1]};
                f[i8080alu_pkg::FL_CY] = a[0];
            end
            i8080alu_pkg::OP_DAA: begin
                lo = a[3:0];
                hi = a[7:4];
                if (lo > i8080alu_pkg::BCD_MAX || f_in[i8080alu_pkg::FL_AC]) begin
                    r = r + i8080alu_pkg::DAA_LO_ADJ;
                    f[i8080alu_pkg::FL_AC] = (lo > i8080alu_pkg::BCD_MAX);
                end
                // carry only ever gets set here
                if (hi > i8080alu_pkg::BCD_MAX || cy ||
                    (hi == i8080alu_pkg::BCD_MAX && lo > i8080alu_pkg::BCD_MAX)) begin
                    r = r + i8080alu_pkg::DAA_HI_ADJ;
                    f[i8080alu_pkg::FL_CY] = 1'b1;
                end
                f = with_zsp(f, r);
            end
            i8080alu_pkg::OP_CMA: r = ~a;
            i8080alu_pkg::OP_STC: f[i8080alu_pkg::FL_CY] = 1'b1;
            i8080alu_pkg::OP_CMC: f[i8080alu_pkg::FL_CY] = ~f[i8080alu_pkg::FL_CY];
            i8080alu_pkg::OP_DAD: begin
                s17 = {1'b0, wa} + {1'b0, wb};
                o.word_sum = s17[15:0];
                f[i8080alu_pkg::FL_CY] = s17[16];
            end
            default: ;
        endcase
        o.result = r;
        o.flags_out = f;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_alu_vec mk_row(input logic [4:0] func, input logic [7:0] acc,
                                        input logic [7:0] opnd, input logic [7:0] flg,
                                        input logic [15:0] wa, input logic [15:0] wb,
                                        input bit typed, input logic [31:0] want);
        t_alu_vec v;
        v.func  = func;
        v.acc   = acc;
        v.opnd  = opnd;
        v.flg   = flg;
        v.wa    = wa;
        v.wb    = wb;
        v.typed = typed;
        v.want  = i8080alu_pkg::t_alu_result'(want);
        return v;
    endfunction

    // byte with extra weight on the ends and on bcd-like values for daa
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = {i8080alu_pkg::BCD_MAX, b[3:0]};
            3: b = b & 8'h99;
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            w = 16'hFFFF;
        end
        return w;
    endfunction

    function automatic t_alu_vec random_row();
        logic [4:0] func;
        // a few spare codes mixed into the real operations
        if ($urandom_range(0, 99) < 8) begin
            func = 5'($urandom_range(int'(FUNC_SPARE_LO), int'(FUNC_SPARE_HI)));
        end else begin
            func = 5'($urandom_range(0, int'(i8080alu_pkg::OP_DAD)));
        end
        return mk_row(func, pick_byte(), pick_byte(), 8'($urandom), pick_word(), pick_word(),
                      1'b0, 32'h0);
    endfunction

    // hold one input transaction until the block takes it, then log what it owes
    task automatic send_item(input t_alu_vec v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, v.wb, v.wa, v.flg, v.opnd, v.acc, v.func};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(v.typed ? v.want
                                          : alu_predict(v.func, v.acc, v.opnd, v.flg,
                                                        v.wa, v.wb));
    endtask

    // ------------------------------------------------------------------------
    // directed rows: extremes, every operation, ana aux rule, daa cases, spare code
    // typed results are packed as {word_sum, flags_out, result}
    // ------------------------------------------------------------------------
    initial begin
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ADD, 8'h00, 8'h00, 8'h00,
                                   16'hA5C3, 16'h3C5A,
                                   1'b1, {16'h0000, 8'h44, 8'h00}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ADD, 8'hFF, 8'h01, 8'h00,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'h55, 8'h00}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ADC, 8'hFF, 8'hFF, 8'h01,
                                   16'hFFFF, 16'hFFFF, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ADC, 8'h0F, 8'h00, 8'h01,
                                   16'h1234, 16'h4321, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_SUB, 8'h00, 8'h01, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_SBB, 8'h00, 8'hFF, 8'hFF,
                                   16'hFFFF, 16'h0001, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ANA, 8'hFF, 8'hFF, 8'h00,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'h94, 8'hFF}));
        // and of zero still raises aux carry from bit 3 of an input
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ANA, 8'h08, 8'h00, 8'hFF,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_XRA, 8'hAA, 8'hAA, 8'hFF,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_ORA, 8'h80, 8'h01, 8'h11,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_CMP, 8'h42, 8'h42, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_CMP, 8'h01, 8'hFF, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_INR, 8'h00, 8'hFF, 8'h00,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'h54, 8'h00}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_DCR, 8'h00, 8'h00, 8'h01,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'h85, 8'hFF}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_RLC, 8'h80, 8'h00, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_RRC, 8'h01, 8'h00, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_RAL, 8'h80, 8'h00, 8'h01,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_RAR, 8'h01, 8'h00, 8'h01,
                                   16'h0000, 16'h0000, 1'b0, 0));
        // daa with high nibble 9 and low nibble above 9, and with aux carry on a bcd digit
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_DAA, 8'h9A, 8'h00, 8'h00,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_DAA, 8'h15, 8'h00, 8'h10,
                                   16'h0000, 16'h0000, 1'b0, 0));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_CMA, 8'h00, 8'h00, 8'hFF,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'hFF, 8'hFF}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_STC, 8'h5A, 8'h00, 8'h00,
                                   16'hFFFF, 16'hFFFF,
                                   1'b1, {16'h0000, 8'h01, 8'h5A}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_CMC, 8'hA5, 8'h00, 8'hFF,
                                   16'h0000, 16'h0000,
                                   1'b1, {16'h0000, 8'hFE, 8'hA5}));
        stim_rows.push_back(mk_row(i8080alu_pkg::OP_DAD, 8'h3C, 8'h00, 8'h00,
                                   16'hFFFF, 16'h0001,
                                   1'b1, {16'h0000, 8'h01, 8'h3C}));
        stim_rows.push_back(mk_row(FUNC_SPARE_HI, 8'h77, 8'hFF, 8'hD5,
                                   16'hFFFF, 16'hFFFF,
                                   1'b1, {16'h0000, 8'hD5, 8'h77}));
    end

    // ------------------------------------------------------------------------
    // sender: directed rows, then random items in bursts with random gaps
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int burst;
        int gap;
        bit hold_drain;
        bit drained_once;
        sent = 0;
        drained_once = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part back to back
        foreach (stim_rows[i]) begin
            send_item(stim_rows[i]);
        end

        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_item(random_row());
                sent++;
            end
            // long stretches run gap-free, otherwise a short hole in the stream
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            // once mid-run, starve the pipeline until every result is back
            hold_drain = !drained_once && sent >= RANDOM_ITEMS / 2;
            if (hold_drain) begin
                drained_once = 1'b1;
                if (gap == 0) gap = 1;
            end
            if (gap > 0 && sent < RANDOM_ITEMS) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (hold_drain) begin
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // wait for the last results, then give the pipeline time to show strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: back-pressure pattern, redrawn at random from four modes:
    // always ready, mostly ready, mostly stalled, or one long stall then ready
    // ------------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int unsigned rx_mode  = 0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_cycle % 64) >= 40;
        endcase
    end

    // ------------------------------------------------------------------------
    // result checker: every result transaction against the oldest expectation
    // ------------------------------------------------------------------------
    i8080alu_pkg::t_alu_result got_res;
    i8080alu_pkg::t_alu_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = i8080alu_pkg::t_alu_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", m_axis_tdata);
                n_fail++;
            end else begin
                want_res = pending_results.pop_front();
                if (got_res.result !== want_res.result) begin
                    $error("result: expected %h, actual %h", want_res.result, got_res.result);
                    n_fail++;
                end
                if (got_res.flags_out !== want_res.flags_out) begin
                    $error("flags_out: expected %h, actual %h",
                           want_res.flags_out, got_res.flags_out);
                    n_fail++;
                end
                if (got_res.word_sum !== want_res.word_sum) begin
                    $error("word_sum: expected %h, actual %h",
                           want_res.word_sum, got_res.word_sum);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on a hung handshake
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
